>>> rtl/wstd_pkg.sv
`default_nettype none

package wstd_pkg;

	// field widths
	localparam int IDX_W   = 3;
	localparam int ERR_W   = 16;
	localparam int STAMP_W = 32;
	localparam int THR_W   = 16;
	localparam int TMO_W   = 32;

	// stream word layout
	localparam int IDX_LSB   = 0;
	localparam int ERR_LSB   = IDX_LSB + IDX_W;
	localparam int STAMP_LSB = ERR_LSB + ERR_W;
	localparam int S_USED_W  = STAMP_LSB + STAMP_W;
	localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;
	localparam int M_USED_W  = 3;
	localparam int M_DATA_W  = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT   = 2'd1;

	localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd4096;
	localparam logic [TMO_W-1:0] TIMEOUT_RST   = 32'd1000;

	typedef struct packed {
		logic [THR_W-1:0] error_threshold;
		logic [TMO_W-1:0] stuck_timeout;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]        wheel_index;
		logic signed [ERR_W-1:0] steer_error;
		logic [STAMP_W-1:0]      stamp;
		logic                    last_wheel;
	} item_t;

	typedef struct packed {
		logic halt_request;
		logic halt_latched;
		logic wheel_in_tolerance;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/wstd_cfg.sv
`default_nettype none

module wstd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [wstd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wstd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output wstd_pkg::cfg_t                          cfg
);

	wstd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_threshold <= wstd_pkg::THRESHOLD_RST;
			cfg_q.stuck_timeout   <= wstd_pkg::TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wstd_pkg::REG_ERROR_THRESHOLD: begin
					cfg_q.error_threshold <= cfg_data[wstd_pkg::THR_W-1:0];
				end
				wstd_pkg::REG_STUCK_TIMEOUT: begin
					cfg_q.stuck_timeout <= cfg_data[wstd_pkg::TMO_W-1:0];
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/wstd_core.sv
`default_nettype none

module wstd_core #(
	parameter int MAX_WHEELS = 8,
	parameter int TIME_BITS  = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wstd_pkg::item_t      item,
	input  wstd_pkg::cfg_t       cfg,
	output wstd_pkg::res_t       res
);

	// only wheels reachable by the index field get storage
	localparam int IDX_SPAN = 2 ** wstd_pkg::IDX_W;
	localparam int DEPTH    = (MAX_WHEELS < IDX_SPAN) ? MAX_WHEELS : IDX_SPAN;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW       = $clog2(DEPTH + 1);
	localparam int CMP_W    = (TIME_BITS > wstd_pkg::TMO_W) ? TIME_BITS : wstd_pkg::TMO_W;
	localparam logic [KW-1:0] KNOWN_MAX = KW'(DEPTH);

	logic [TIME_BITS-1:0] last_ok_q [DEPTH];
	logic [KW-1:0]        known_q;
	logic                 all_ok_q;
	logic                 halt_q;

	logic [wstd_pkg::ERR_W-1:0] raw;
	logic [wstd_pkg::ERR_W-1:0] mag;
	logic                       ok;
	logic                       in_range;
	logic                       fresh;
	logic [AW-1:0]              addr;
	logic [TIME_BITS-1:0]       now;
	logic [TIME_BITS-1:0]       base;
	logic [TIME_BITS-1:0]       elapsed;
	logic                       expired;
	logic                       pulse;
	logic                       halt_mid;
	logic                       all_ok_mid;
	logic [wstd_pkg::IDX_W:0]   count_n;
	logic [KW-1:0]              known_n;
	logic                       halt_n;
	logic                       all_ok_n;
	logic                       wr_en;

	always_comb begin
		raw = $unsigned(item.steer_error);
		// full negative value folds to 32768, which still fits unsigned
		mag = raw[wstd_pkg::ERR_W-1] ? (~raw + 1'b1) : raw;
		ok  = mag < cfg.error_threshold;

		in_range = int'(item.wheel_index) < DEPTH;
		fresh    = int'(item.wheel_index) >= int'(known_q);
		addr     = item.wheel_index[AW-1:0];
		now      = TIME_BITS'(item.stamp);

		// a wheel new to this message starts from the stamp
		base    = fresh ? now : last_ok_q[addr];
		elapsed = now - base;
		expired = CMP_W'(elapsed) >= CMP_W'(cfg.stuck_timeout);

		if (in_range) begin
			pulse = !ok && expired && !halt_q;
		end else begin
			pulse = !ok && (cfg.stuck_timeout == '0) && !halt_q;
		end

		halt_mid   = halt_q | pulse;
		all_ok_mid = all_ok_q & ok;

		count_n = {1'b0, item.wheel_index} + 1'b1;
		known_n = (int'(count_n) > DEPTH) ? KNOWN_MAX : KW'(count_n);

		if (item.last_wheel) begin
			halt_n   = halt_mid & ~all_ok_mid;
			all_ok_n = 1'b1;
		end else begin
			halt_n   = halt_mid;
			all_ok_n = all_ok_mid;
		end

		wr_en = in_range && (fresh || ok);

		res.halt_request       = pulse;
		res.halt_latched       = halt_n;
		res.wheel_in_tolerance = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				last_ok_q[i] <= '0;
			end
			known_q  <= '0;
			all_ok_q <= 1'b1;
			halt_q   <= 1'b0;
		end else if (step) begin
			if (wr_en) begin
				last_ok_q[addr] <= now;
			end
			if (item.last_wheel) begin
				known_q <= known_n;
			end
			all_ok_q <= all_ok_n;
			halt_q   <= halt_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/wheel_stuck_timeout_detector.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: wheel_index, steer_error, stamp; s_tlast
// m_*       out        m_tvalid / m_tready  m_tdata: halt_request, halt_latched, wheel_in_tolerance
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One wheel word per clock unless m_tready stalls; each word is held in the input register,
// its result is then captured in the result register and wheel state updates in that same
// cycle, so back-to-back words see each other's effects with no bubble.
// Reset clears all wheel times, the halt latch and both valid flags; the limits return
// to threshold 4096 and timeout 1000. A stall on m_tready holds both registers and
// drops s_tready once both are full.

module wheel_stuck_timeout_detector #(
	parameter int MAX_WHEELS = 8,
	parameter int TIME_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// [2:0] wheel_index, [18:3] steer_error, [50:19] stamp, [55:51] zero
	input  wire logic [wstd_pkg::S_DATA_W-1:0]     s_tdata,
	input  wire logic                              s_tlast,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// [0] halt_request, [1] halt_latched, [2] wheel_in_tolerance, [7:3] zero
	output      logic [wstd_pkg::M_DATA_W-1:0]     m_tdata,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [wstd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wstd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	wstd_pkg::cfg_t  cfg;
	wstd_pkg::item_t item_s1;
	wstd_pkg::res_t  res;
	logic            valid_s1;
	logic            advance;

	assign cfg_ready = 1'b1;

	wstd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.wheel_index <= s_tdata[wstd_pkg::IDX_LSB +: wstd_pkg::IDX_W];
			item_s1.steer_error <= $signed(s_tdata[wstd_pkg::ERR_LSB +: wstd_pkg::ERR_W]);
			item_s1.stamp       <= s_tdata[wstd_pkg::STAMP_LSB +: wstd_pkg::STAMP_W];
			item_s1.last_wheel  <= s_tlast;
		end
	end

	wstd_core #(
		.MAX_WHEELS (MAX_WHEELS),
		.TIME_BITS  (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {(wstd_pkg::M_DATA_W - wstd_pkg::M_USED_W)'(0),
				res.wheel_in_tolerance, res.halt_latched, res.halt_request};
		end
	end

	// a new halt always leaves the latch set on the same word
	a_pulse_latched: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("halt_request without halt_latched");

	// only an out-of-tolerance wheel can raise a halt
	a_pulse_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[2])
		else $error("halt_request on a wheel in tolerance");

	// a held input word is never lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped a word");

endmodule

`default_nettype wire
